// ===== hw/rtl/wfrm_pkg.sv =====
// Shared constants and controller/datapath command and status types of the windowed frame rate meter.
// No dependencies.
package wfrm_pkg;

  localparam int TS_W          = 32;
  localparam int FPS_W         = 24;
  localparam int VF_W          = 6;
  localparam int MS_Q8_W       = 18;
  localparam int DEFAULT_WINDOW_FRAMES = 60;

  localparam logic [FPS_W-1:0]   RATE_RESET = 24'd15360;
  localparam logic [FPS_W-1:0]   FPS_MAX    = 24'hFF_FFFF;
  localparam logic [VF_W-1:0]    VF_MAX     = 6'd63;
  localparam logic [MS_Q8_W-1:0] MS_Q8      = 18'd256000;

  typedef struct packed {
    logic capture;
    logic update;
    logic div_start;
    logic out_load;
  } wfrm_cmd_t;

  typedef struct packed {
    logic enable;
    logic rate_ok;
    logic div_done;
  } wfrm_sts_t;

endpackage

// ===== hw/rtl/wfrm_intf.sv =====
// Valid/ready channel interfaces: frame events in, rate results out, enable writes.
// Depends on wfrm_pkg.
interface wfrm_in_if;
  import wfrm_pkg::*;
  logic            valid;
  logic            ready;
  logic [TS_W-1:0] timestamp_ms;
  modport source (output valid, output timestamp_ms, input ready);
  modport sink   (input valid, input timestamp_ms, output ready);
endinterface

interface wfrm_out_if;
  import wfrm_pkg::*;
  logic             valid;
  logic             ready;
  logic [FPS_W-1:0] fps_q8;
  logic [VF_W-1:0]  frame_count;
  modport source (output valid, output fps_q8, output frame_count, input ready);
  modport sink   (input valid, input fps_q8, input frame_count, output ready);
endinterface

interface wfrm_cfg_if;
  logic valid;
  logic ready;
  logic enable;
  modport source (output valid, output enable, input ready);
  modport sink   (input valid, input enable, output ready);
endinterface

// ===== hw/rtl/wfrm_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module wfrm_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 38
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);
  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q, done_q;
  logic [DEN_W:0]    shifted, diff;
  logic              ge;

  always_comb begin
    shifted = {rem_q, num_q[NUM_W-1]};
    ge      = shifted >= {1'b0, den_q};
    diff    = shifted - {1'b0, den_q};
    rem_d   = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(NUM_W);
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;
endmodule

// ===== hw/rtl/wfrm_dpath.sv =====
// Datapath: timestamp delta, frame-time ring, window sum and count, rate and result registers.
// Depends on wfrm_pkg and wfrm_div.
module wfrm_dpath #(
  parameter int WINDOW_FRAMES = wfrm_pkg::DEFAULT_WINDOW_FRAMES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [wfrm_pkg::TS_W-1:0]  timestamp_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_enable_i,
  output logic                       cfg_ready_o,
  input  wfrm_pkg::wfrm_cmd_t        cmd_i,
  output wfrm_pkg::wfrm_sts_t        sts_o,
  output logic [wfrm_pkg::FPS_W-1:0] fps_q8_o,
  output logic [wfrm_pkg::VF_W-1:0]  frame_count_o
);
  import wfrm_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_FRAMES);
  localparam int CNT_W = $clog2(WINDOW_FRAMES + 1);
  localparam int SUM_W = TS_W + $clog2(WINDOW_FRAMES);
  localparam int NUM_W = CNT_W + MS_Q8_W;

  logic                     enable_q;
  logic                     primed_q;
  logic [TS_W-1:0]          prev_q;
  logic [TS_W-1:0]          delta_q;
  logic [TS_W-1:0]          rd_q;
  logic                     rd_vld_q;
  logic [TS_W-1:0]          ring_mem [WINDOW_FRAMES];
  logic [WINDOW_FRAMES-1:0] vld_q;
  logic [IDX_W-1:0]         pos_q;
  logic [SUM_W-1:0]         sum_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [FPS_W-1:0]         rate_q;
  logic [FPS_W-1:0]         fps_q;
  logic [VF_W-1:0]          vf_q;
  logic [TS_W-1:0]          old_val;
  logic [NUM_W-1:0]         num;
  logic                     div_done;
  logic [NUM_W-1:0]         quot;
  logic [NUM_W+FPS_W-1:0]   quot_ext, fps_max_ext;
  logic [CNT_W+VF_W-1:0]    cnt_ext, vf_max_ext;

  assign old_val     = rd_vld_q ? rd_q : '0;
  assign num         = NUM_W'(cnt_q) * NUM_W'(MS_Q8);
  assign quot_ext    = {{FPS_W{1'b0}}, quot};
  assign fps_max_ext = {{NUM_W{1'b0}}, FPS_MAX};
  assign cnt_ext     = {{VF_W{1'b0}}, cnt_q};
  assign vf_max_ext  = {{CNT_W{1'b0}}, VF_MAX};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      primed_q <= 1'b0;
      prev_q   <= '0;
      vld_q    <= '0;
      pos_q    <= '0;
      sum_q    <= '0;
      cnt_q    <= '0;
      rate_q   <= RATE_RESET;
    end else begin
      if (cfg_valid_i) begin
        enable_q <= cfg_enable_i;
      end
      if (cmd_i.capture) begin
        primed_q <= 1'b1;
        prev_q   <= timestamp_i;
      end
      if (cmd_i.update) begin
        vld_q[pos_q] <= 1'b1;
        sum_q <= sum_q - SUM_W'(old_val) + SUM_W'(delta_q);
        cnt_q <= cnt_q - CNT_W'(old_val != '0) + CNT_W'(delta_q != '0);
        pos_q <= (pos_q == IDX_W'(WINDOW_FRAMES - 1)) ? '0 : pos_q + IDX_W'(1);
      end
      if (div_done) begin
        rate_q <= (quot_ext > fps_max_ext) ? FPS_MAX : quot_ext[FPS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      delta_q  <= primed_q ? timestamp_i - prev_q : '0;
      rd_q     <= ring_mem[pos_q];
      rd_vld_q <= vld_q[pos_q];
    end
    if (cmd_i.update) begin
      ring_mem[pos_q] <= delta_q;
    end
    if (cmd_i.out_load) begin
      fps_q <= rate_q;
      vf_q  <= (cnt_ext > vf_max_ext) ? VF_MAX : cnt_ext[VF_W-1:0];
    end
  end

  wfrm_div #(
    .NUM_W(NUM_W),
    .DEN_W(SUM_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (num),
    .den_i  (sum_q),
    .done_o (div_done),
    .quot_o (quot)
  );

  assign cfg_ready_o    = 1'b1;
  assign sts_o.enable   = enable_q;
  assign sts_o.rate_ok  = (sum_q != '0) && (cnt_q != '0);
  assign sts_o.div_done = div_done;
  assign fps_q8_o       = fps_q;
  assign frame_count_o  = vf_q;
endmodule

// ===== hw/rtl/wfrm_ctrl.sv =====
// Controller: sequences capture, ring update, division and result load for each frame beat.
// Depends on wfrm_pkg.
module wfrm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  wfrm_pkg::wfrm_sts_t sts_i,
  output wfrm_pkg::wfrm_cmd_t cmd_o
);
  import wfrm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_CHECK,
    S_DIV,
    S_EMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   load;

  assign load = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o.capture   = (state_q == S_IDLE) && in_valid_i && sts_i.enable;
    cmd_o.update    = (state_q == S_UPD);
    cmd_o.div_start = (state_q == S_CHECK) && sts_i.rate_ok;
    cmd_o.out_load  = load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= sts_i.enable ? S_UPD : S_EMIT;
          end
        end
        S_UPD: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          state_q <= sts_i.rate_ok ? S_DIV : S_EMIT;
        end
        S_DIV: begin
          if (sts_i.div_done) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
endmodule

// ===== hw/rtl/windowed_frame_rate_meter.sv =====
// Top level of the windowed frame rate meter: controller plus datapath.
// Depends on wfrm_pkg, wfrm_intf, wfrm_ctrl and wfrm_dpath.
//
//   channel   dir  handshake           payload
//   cfg_i     in   valid/ready         enable (1 bit)
//   frame_i   in   valid/ready         timestamp_ms (32 bits)
//   rate_o    out  valid/ready         fps_q8 (24 bits), frame_count (6 bits)
//
// A frame beat runs through the idle and emit states when disabled, through idle, update,
// check and emit when the window sum is zero, and otherwise also through a division by the
// restoring divider that retires one quotient bit per cycle.
// Reset clears the ring through per-entry valid bits; no clearing pass is needed.
// The next frame beat is taken while a result waits in the output register; it
// holds in the emit state until that result is taken.
// Configuration writes are always accepted.
module windowed_frame_rate_meter #(
  parameter int WINDOW_FRAMES = wfrm_pkg::DEFAULT_WINDOW_FRAMES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wfrm_cfg_if.sink    cfg_i,
  wfrm_in_if.sink     frame_i,
  wfrm_out_if.source  rate_o
);
  import wfrm_pkg::*;

  wfrm_cmd_t cmd;
  wfrm_sts_t sts;

  wfrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (frame_i.valid),
    .in_ready_o (frame_i.ready),
    .out_valid_o(rate_o.valid),
    .out_ready_i(rate_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wfrm_dpath #(
    .WINDOW_FRAMES(WINDOW_FRAMES)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .timestamp_i   (frame_i.timestamp_ms),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_enable_i  (cfg_i.enable),
    .cfg_ready_o   (cfg_i.ready),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .fps_q8_o      (rate_o.fps_q8),
    .frame_count_o (rate_o.frame_count)
  );
endmodule
